// File: hdl/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the window generator checkers.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Expression that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `ASSERT_CLK(label, clk, rst_n, !(expr), msg)

`endif

// File: hdl/bwg_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Blackman window generator package
// Fixed widths, coefficient constants, status codes and the cosine table.
// ============================================================================
package bwg_pkg;

    localparam int COEF_WIDTH = 24;
    localparam int FRAC_BITS  = COEF_WIDTH - 2;
    localparam int W_SHIFT    = 60 - FRAC_BITS;
    localparam int COS_DEPTH  = 1024;
    localparam int COS_AW     = $clog2(COS_DEPTH);

    // Status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SHORT = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // Opcodes.
    localparam logic OP_BUILD = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [1:0] CFG_NORMALIZE_SUM = 2'd1;
    localparam logic [1:0] CFG_EXACT_COEFFS  = 2'd2;

    localparam logic [63:0] ONE30      = 64'd1 << 30;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    // Window coefficients in Q30, rounded to nearest.
    localparam logic signed [31:0] A0_CLASSIC = 32'(((64'd42 << 30) + 64'd50) / 64'd100);
    localparam logic signed [31:0] A1_CLASSIC = 32'(ONE30 >> 1);
    localparam logic signed [31:0] A2_CLASSIC = 32'(((64'd8 << 30) + 64'd50) / 64'd100);
    localparam logic signed [31:0] A0_EXACT   =
        32'(((64'd7938 << 30) + 64'd9304) / 64'd18608);
    localparam logic signed [31:0] A1_EXACT   =
        32'(((64'd9240 << 30) + 64'd9304) / 64'd18608);
    localparam logic signed [31:0] A2_EXACT   =
        32'(((64'd1430 << 30) + 64'd9304) / 64'd18608);

    typedef logic signed [31:0] t_cos_table [COS_DEPTH];

    // cos(pi/2 * u / 2^30) in Q30 by a truncating Horner series.
    function automatic logic [63:0] quarter_cos(input logic [63:0] u);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] c;
        logic [63:0] d;
        x  = (u * TWO_PI_Q30) >> 32;
        x2 = (x * x) >> 30;
        c  = ONE30;
        for (int n = 8; n >= 1; n--) begin
            d = ((x2 * c) >> 30) / 64'((2 * n) * (2 * n - 1));
            c = (d >= ONE30) ? 64'd0 : ONE30 - d;
        end
        return c;
    endfunction

    function automatic t_cos_table build_cos_table();
        t_cos_table tab;
        logic [63:0] t;
        logic [63:0] half;
        logic [63:0] quarter;
        logic signed [63:0] v;
        half    = 64'd1 << 31;
        quarter = 64'd1 << 30;
        for (int k = 0; k < COS_DEPTH; k++) begin
            t = 64'(k) << (32 - COS_AW);
            if (t <= quarter) begin
                v = signed'(quarter_cos(t));
            end else if (t <= half) begin
                v = -signed'(quarter_cos(half - t));
            end else if (t <= half + quarter) begin
                v = -signed'(quarter_cos(t - half));
            end else begin
                v = signed'(quarter_cos((64'd1 << 32) - t));
            end
            tab[k] = 32'(v);
        end
        return tab;
    endfunction

    localparam t_cos_table COS_TABLE = build_cos_table();

endpackage

// File: hdl/bwg_div.sv
`timescale 1ns / 1ps
// ============================================================================
// Serial divider
// Restoring unsigned divider, one quotient bit per clock cycle.
// ============================================================================
module bwg_div #(
    parameter int DW = 47,
    parameter int VW = 36
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot,
    output logic [VW-1:0] o_rem
);
    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [DW-1:0] r_q;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;
    logic [VW:0]   trial;

    assign trial = {r_rem, r_q[DW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(DW);
                r_rem <= '0;
                r_q   <= i_dividend;
                r_div <= i_divisor;
            end else if (r_cnt != '0) begin
                if (trial >= {1'b0, r_div}) begin
                    r_rem <= VW'(trial - {1'b0, r_div});
                    r_q   <= {r_q[DW-2:0], 1'b1};
                end else begin
                    r_rem <= trial[VW-1:0];
                    r_q   <= {r_q[DW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;
endmodule

// File: hdl/blackman_window_generator_core.sv
`timescale 1ns / 1ps
// ============================================================================
// Blackman window generator core
// A build beat fills an on-chip coefficient store with a Blackman window of
// the configured length, optionally normalised to unit sum; a read beat
// returns one stored coefficient in signed Q2.22 with a status code. One
// input beat is worked on at a time. An in-range read passes the memory read
// and the result register before the next accept. A build first sets up the
// phase step on the serial divider, then takes each coefficient through the
// phase, cosine table, multiply, accumulate and store-write states with the
// single shared multiplier; with normalisation on, each coefficient then
// passes through the serial divider again, followed by the middle-entry
// correction. The result of a finished beat waits in the output register, so
// a new input beat may be taken while it is still unclaimed.
// ============================================================================
module blackman_window_generator_core #(
    parameter int MAX_LENGTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [11:0] coef_index
    input  logic [0:0]  i_s_axis_tuser,   // [0] opcode
    // Result stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [bwg_pkg::COEF_WIDTH-1:0] o_m_axis_tdata, // coefficient
    output logic [1:0]  o_m_axis_tuser,   // [1:0] status
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [12:0] i_cfg_wdata
);
    import bwg_pkg::*;

    localparam int AW     = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int LW     = $clog2(MAX_LENGTH + 1);
    localparam int SUM_W  = COEF_WIDTH + LW + 1;
    localparam int DIV_DW = (2 * COEF_WIDTH - 1 > SUM_W) ? 2 * COEF_WIDTH - 1 : SUM_W;
    localparam int CLW    = (LW > 13) ? LW : 13;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RD    = 4'd1;
    localparam logic [3:0] ST_DIVP  = 4'd2;
    localparam logic [3:0] ST_PH    = 4'd3;
    localparam logic [3:0] ST_C1    = 4'd4;
    localparam logic [3:0] ST_C2    = 4'd5;
    localparam logic [3:0] ST_ACC   = 4'd6;
    localparam logic [3:0] ST_WR    = 4'd7;
    localparam logic [3:0] ST_NRD   = 4'd8;
    localparam logic [3:0] ST_NDIV0 = 4'd9;
    localparam logic [3:0] ST_NDIV  = 4'd10;
    localparam logic [3:0] ST_FIX   = 4'd11;
    localparam logic [3:0] ST_OUT   = 4'd12;

    localparam logic signed [SUM_W+1:0] ONE_Q = (SUM_W+2)'(1) << FRAC_BITS;

    // Configuration registers.
    logic [12:0] r_wlen;
    logic        r_norm;
    logic        r_exact;

    // Sequencer and build state.
    logic [3:0]  r_state;
    logic        r_built;
    logic [LW-1:0] r_blen;
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_den;
    logic [LW-1:0] r_l;
    logic [32:0] r_q0;
    logic [LW-1:0] r_r0;
    logic [32:0] r_q1;
    logic [LW-1:0] r_r1;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] r_sum2;
    logic signed [COEF_WIDTH-1:0] r_mid;
    logic        r_wneg;

    // Result waiting for the output register, and the output register.
    logic [COEF_WIDTH-1:0] r_res_coef;
    logic [1:0]  r_res_status;
    logic        r_out_valid;
    logic [COEF_WIDTH-1:0] r_out_coef;
    logic [1:0]  r_out_status;
    logic        out_load;

    // Coefficient store and cosine table read data.
    logic [COEF_WIDTH-1:0] mem [MAX_LENGTH];
    logic [COEF_WIDTH-1:0] r_mem_q;
    logic signed [31:0]    r_rom_q;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [COEF_WIDTH-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [COS_AW-1:0] rom_addr;

    logic          s_accept;
    logic          in_op;
    logic [11:0]   in_idx;
    logic [CLW-1:0] len_ext;
    logic [LW-1:0] len_c;
    logic          rd_bad;

    logic [31:0]   ph1;
    logic [31:0]   ph2;
    logic [31:0]   ph1_r;
    logic [31:0]   ph2_r;
    logic [COS_AW-1:0] idx1;
    logic [COS_AW-1:0] idx2;
    logic          half_up;
    logic [LW:0]   r_step;

    logic signed [31:0] a0;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
    logic signed [31:0] mul_a;
    logic signed [63:0] mul_p;

    logic [63:0]   w_mag;
    logic [63:0]   w_rnd;
    logic [COEF_WIDTH-1:0] w_val;
    logic signed [SUM_W-1:0] sum_nx;
    logic [COEF_WIDTH-1:0] n_val;
    logic signed [SUM_W-1:0] sum2_nx;
    logic signed [SUM_W+1:0] fix_val;
    logic [63:0]   fix_mag;
    logic [COEF_WIDTH-1:0] fix_sat;
    logic signed [COEF_WIDTH-1:0] rd_w;
    logic [COEF_WIDTH:0] rd_mag;

    logic          div_start;
    logic [DIV_DW-1:0] div_dividend;
    logic [SUM_W-1:0]  div_divisor;
    logic          div_done;
    logic [DIV_DW-1:0] div_quot;
    logic [SUM_W-1:0]  div_rem;

    // Saturate a sign and magnitude to the coefficient width.
    function automatic logic [COEF_WIDTH-1:0] sat_mag(input logic neg, input logic [63:0] mag);
        logic [63:0] lim;
        lim = 64'd1 << (COEF_WIDTH - 1);
        if (neg) begin
            if (mag > lim) begin
                return {1'b1, {(COEF_WIDTH-1){1'b0}}};
            end
            return COEF_WIDTH'(64'd0 - mag);
        end
        if (mag > lim - 64'd1) begin
            return {1'b0, {(COEF_WIDTH-1){1'b1}}};
        end
        return COEF_WIDTH'(mag);
    endfunction

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign in_op    = i_s_axis_tuser[0];
    assign in_idx   = i_s_axis_tdata[11:0];

    // The finished result moves into the output register once it is free.
    assign out_load = (r_state == ST_OUT) && (!r_out_valid || i_m_axis_tready);

    // Lengths above the store size are clamped to it.
    assign len_ext = (CLW'(r_wlen) > CLW'(MAX_LENGTH)) ? CLW'(MAX_LENGTH) : CLW'(r_wlen);
    assign len_c   = LW'(len_ext);
    assign rd_bad  = !r_built || ((CLW+1)'(in_idx) >= (CLW+1)'(r_blen))
                  || ((CLW+1)'(in_idx) >= (CLW+1)'(MAX_LENGTH));

    // Phase of the current entry: q1 + r1/den = l * 2^32 / den. The double
    // angle follows from the same quotient and remainder.
    assign half_up = ({r_r1, 1'b0} >= {1'b0, r_den});
    assign ph1     = r_q1[31:0];
    assign ph2     = {r_q1[30:0], half_up};
    assign ph1_r   = ph1 + (32'd1 << (31 - COS_AW));
    assign ph2_r   = ph2 + (32'd1 << (31 - COS_AW));
    assign idx1    = ph1_r[31 -: COS_AW];
    assign idx2    = ph2_r[31 -: COS_AW];
    assign r_step  = {1'b0, r_r1} + {1'b0, r_r0};

    assign a0 = r_exact ? A0_EXACT : A0_CLASSIC;
    assign a1 = r_exact ? A1_EXACT : A1_CLASSIC;
    assign a2 = r_exact ? A2_EXACT : A2_CLASSIC;

    // The one shared multiplier.
    assign mul_a = (r_state == ST_C1) ? a1 : a2;
    assign mul_p = mul_a * r_rom_q;

    // Round the Q60 sum half away from zero to Q2.22.
    assign w_mag  = r_acc[63] ? 64'(-r_acc) : 64'(r_acc);
    assign w_rnd  = (w_mag + (64'd1 << (W_SHIFT - 1))) >> W_SHIFT;
    assign w_val  = sat_mag(r_acc[63], w_rnd);
    assign sum_nx = r_sum + SUM_W'(signed'(w_val));

    // Normalised entry from the divider.
    assign n_val   = sat_mag(r_wneg, 64'(div_quot));
    assign sum2_nx = r_sum2 + SUM_W'(signed'(n_val));

    // Residual correction of the middle entry.
    assign fix_val = (SUM_W+2)'(r_mid) + ONE_Q - (SUM_W+2)'(r_sum2);
    assign fix_mag = fix_val[SUM_W+1] ? 64'(-fix_val) : 64'(fix_val);
    assign fix_sat = sat_mag(fix_val[SUM_W+1], fix_mag);

    assign rd_w   = signed'(r_mem_q);
    assign rd_mag = rd_w[COEF_WIDTH-1] ? (COEF_WIDTH+1)'(-rd_w) : (COEF_WIDTH+1)'(rd_w);

    // Divider operands: the phase step at the start of a build, then one
    // division per entry while normalising.
    always_comb begin
        div_start    = 1'b0;
        div_dividend = DIV_DW'(64'd1 << 32);
        div_divisor  = SUM_W'(len_c - 1'b1);
        if (r_state == ST_IDLE) begin
            div_start = s_accept && (in_op == OP_BUILD) && (len_c >= LW'(2));
        end else if (r_state == ST_NDIV0) begin
            div_start    = 1'b1;
            div_dividend = (DIV_DW'(rd_mag) << FRAC_BITS) + DIV_DW'(r_sum >>> 1);
            div_divisor  = SUM_W'(r_sum);
        end
    end

    bwg_div #(
        .DW (DIV_DW),
        .VW (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Store and table ports.
    always_comb begin
        mem_raddr = AW'(r_l);
        if (r_state == ST_IDLE) begin
            mem_raddr = AW'(in_idx);
        end
        rom_addr = (r_state == ST_C1) ? idx2 : idx1;

        mem_we    = 1'b0;
        mem_waddr = AW'(r_l);
        mem_wdata = w_val;
        unique case (r_state)
            ST_WR: begin
                mem_we = 1'b1;
            end
            ST_NDIV: begin
                mem_we    = div_done;
                mem_wdata = n_val;
            end
            ST_FIX: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_len >> 1);
                mem_wdata = fix_sat;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= mem[mem_raddr];
        r_rom_q <= COS_TABLE[rom_addr];
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen  <= 13'd64;
            r_norm  <= 1'b0;
            r_exact <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_WINDOW_LENGTH: r_wlen  <= i_cfg_wdata;
                CFG_NORMALIZE_SUM: r_norm  <= i_cfg_wdata[0];
                CFG_EXACT_COEFFS:  r_exact <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_built     <= 1'b0;
            r_blen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_accept) begin
                        r_res_coef <= '0;
                        if (in_op == OP_READ) begin
                            if (rd_bad) begin
                                r_res_status <= STATUS_RANGE;
                                r_state      <= ST_OUT;
                            end else begin
                                r_res_status <= STATUS_OK;
                                r_state      <= ST_RD;
                            end
                        end else if (len_c < LW'(2)) begin
                            r_res_status <= STATUS_SHORT;
                            r_state      <= ST_OUT;
                        end else begin
                            r_res_status <= STATUS_OK;
                            r_len        <= len_c;
                            r_den        <= len_c - 1'b1;
                            r_state      <= ST_DIVP;
                        end
                    end
                end
                ST_RD: begin
                    r_res_coef <= r_mem_q;
                    r_state    <= ST_OUT;
                end
                ST_DIVP: begin
                    if (div_done) begin
                        r_q0    <= div_quot[32:0];
                        r_r0    <= div_rem[LW-1:0];
                        r_q1    <= '0;
                        r_r1    <= '0;
                        r_l     <= '0;
                        r_sum   <= '0;
                        r_state <= ST_PH;
                    end
                end
                ST_PH: begin
                    r_state <= ST_C1;
                end
                ST_C1: begin
                    r_prod  <= mul_p;
                    r_state <= ST_C2;
                end
                ST_C2: begin
                    r_acc   <= (64'(a0) <<< 30) - r_prod;
                    r_prod  <= mul_p;
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    r_acc   <= r_acc + r_prod;
                    r_state <= ST_WR;
                end
                ST_WR: begin
                    r_sum <= sum_nx;
                    if (r_l == r_den) begin
                        r_l    <= '0;
                        r_sum2 <= '0;
                        if (r_norm && (sum_nx > 0)) begin
                            r_state <= ST_NRD;
                        end else begin
                            r_built <= 1'b1;
                            r_blen  <= r_len;
                            r_state <= ST_OUT;
                        end
                    end else begin
                        r_l <= r_l + 1'b1;
                        if (r_step >= {1'b0, r_den}) begin
                            r_r1 <= LW'(r_step - {1'b0, r_den});
                            r_q1 <= r_q1 + r_q0 + 33'd1;
                        end else begin
                            r_r1 <= LW'(r_step);
                            r_q1 <= r_q1 + r_q0;
                        end
                        r_state <= ST_PH;
                    end
                end
                ST_NRD: begin
                    r_state <= ST_NDIV0;
                end
                ST_NDIV0: begin
                    r_wneg  <= rd_w[COEF_WIDTH-1];
                    r_state <= ST_NDIV;
                end
                ST_NDIV: begin
                    if (div_done) begin
                        r_sum2 <= sum2_nx;
                        if (r_l == (r_len >> 1)) begin
                            r_mid <= signed'(n_val);
                        end
                        if (r_l == r_den) begin
                            r_state <= ST_FIX;
                        end else begin
                            r_l     <= r_l + 1'b1;
                            r_state <= ST_NRD;
                        end
                    end
                end
                ST_FIX: begin
                    r_built <= 1'b1;
                    r_blen  <= r_len;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_out_coef   <= r_res_coef;
                        r_out_status <= r_res_status;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_coef;
    assign o_m_axis_tuser  = r_out_status;
endmodule

// File: hdl/bwg_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// Blackman window generator checker
// Port-level assertions on the core, attached by a bind statement.
// ============================================================================
`include "assert_macros.svh"

module bwg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [bwg_pkg::COEF_WIDTH-1:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);
    import bwg_pkg::*;

    // A result beat stays offered until it is taken.
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid, "result beat dropped before it was taken")

    // Only the three defined status codes appear.
    `ASSERT_NEVER(a_status_code, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tuser != STATUS_OK) && (o_m_axis_tuser != STATUS_SHORT) && (o_m_axis_tuser != STATUS_RANGE), "undefined status code")

    // An error result carries a zero coefficient.
    `ASSERT_CLK(a_err_zero, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tuser != STATUS_OK) |-> (o_m_axis_tdata == '0), "error result with a non-zero coefficient")

    // The core works on one beat at a time.
    `ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready, "input taken again straight after an accept")
endmodule

bind blackman_window_generator_core bwg_checker u_bwg_checker (.*);

// File: tb/tb_blackman_window_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blackman window generator core testbench
// Drives build and read beats with random gaps and back-pressure, predicts
// every result with a self-contained model of the fixed-point window build,
// and checks each result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------

// Window model and store of predicted results.
class window_scoreboard;
    typedef struct {
        logic signed [23:0] coef;
        logic [1:0]         status;
    } t_result;

    t_result     awaited[$];
    longint      cos_lut[1024];
    int          coef_mem[4096];
    bit          built;
    int unsigned built_len;
    int unsigned cfg_len;
    bit          cfg_norm;
    bit          cfg_exact;
    int unsigned errors;

    function new();
        longint t;
        built     = 0;
        built_len = 0;
        cfg_len   = 64;
        cfg_norm  = 0;
        cfg_exact = 0;
        errors    = 0;
        for (int k = 0; k < 1024; k++) begin
            t = longint'(k) << 22;
            if (t <= (64'd1 << 30))
                cos_lut[k] = longint'(qcos(t));
            else if (t <= (64'd1 << 31))
                cos_lut[k] = -longint'(qcos((64'd1 << 31) - t));
            else if (t <= (64'd3 << 30))
                cos_lut[k] = -longint'(qcos(t - (64'd1 << 31)));
            else
                cos_lut[k] = longint'(qcos((64'd1 << 32) - t));
        end
    endfunction

    // Quarter-wave cosine in Q30 by a truncating Horner series.
    function bit [63:0] qcos(bit [63:0] u);
        bit [63:0] x;
        bit [63:0] x2;
        bit [63:0] c;
        bit [63:0] d;
        x  = (u * 64'd6746518852) >> 32;
        x2 = (x * x) >> 30;
        c  = 64'd1 << 30;
        for (int n = 8; n >= 1; n--) begin
            d = ((x2 * c) >> 30) / 64'((2 * n) * (2 * n - 1));
            c = (d >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - d;
        end
        return c;
    endfunction

    function longint lut_cos(longint ph);
        longint idx;
        idx = (ph * 1024 + (64'sd1 << 31)) >>> 32;
        if (idx >= 1024) idx = 0;
        return cos_lut[idx];
    endfunction

    function longint sat24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function longint rnd_shift(longint v, int s);
        longint half;
        half = 64'sd1 << (s - 1);
        if (v >= 0) return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    function longint rnd_div(longint n, longint d);
        longint m;
        m = (n < 0) ? -n : n;
        m = (m + d / 2) / d;
        return (n < 0) ? -m : m;
    endfunction

    function void set_cfg(logic [1:0] addr, logic [12:0] data);
        case (addr)
            bwg_pkg::CFG_WINDOW_LENGTH: cfg_len   = data;
            bwg_pkg::CFG_NORMALIZE_SUM: cfg_norm  = data[0];
            bwg_pkg::CFG_EXACT_COEFFS:  cfg_exact = data[0];
            default: ;
        endcase
    endfunction

    function void fill_window(int unsigned len);
        longint a0, a1, a2, den, ph1, ph2, w, sum, sum2, one;
        if (cfg_exact) begin
            a0 = ((64'sd7938 << 30) + 9304) / 18608;
            a1 = ((64'sd9240 << 30) + 9304) / 18608;
            a2 = ((64'sd1430 << 30) + 9304) / 18608;
        end else begin
            a0 = ((64'sd42 << 30) + 50) / 100;
            a1 = 64'sd1 << 29;
            a2 = ((64'sd8 << 30) + 50) / 100;
        end
        den = len - 1;
        sum = 0;
        for (int l = 0; l < len; l++) begin
            ph1 = ((longint'(l) << 32) / den) & 64'hFFFF_FFFF;
            ph2 = ((longint'(2 * l) << 32) / den) & 64'hFFFF_FFFF;
            w = a0 * (64'sd1 << 30) - a1 * lut_cos(ph1) + a2 * lut_cos(ph2);
            coef_mem[l] = int'(sat24(rnd_shift(w, 38)));
            sum += coef_mem[l];
        end
        // A window summing to zero or less is stored unscaled.
        if (cfg_norm && sum > 0) begin
            one  = 64'sd1 << 22;
            sum2 = 0;
            for (int l = 0; l < len; l++) begin
                coef_mem[l] = int'(sat24(rnd_div(longint'(coef_mem[l]) * one, sum)));
                sum2 += coef_mem[l];
            end
            coef_mem[len / 2] = int'(sat24(longint'(coef_mem[len / 2]) + one - sum2));
        end
        built     = 1;
        built_len = len;
    endfunction

    function void note_input(logic op, logic [11:0] idx);
        t_result r;
        int unsigned len;
        r.coef   = '0;
        r.status = bwg_pkg::STATUS_OK;
        if (op == bwg_pkg::OP_BUILD) begin
            len = (cfg_len > 4096) ? 4096 : cfg_len;
            if (len < 2) r.status = bwg_pkg::STATUS_SHORT;
            else fill_window(len);
        end else if (!built || idx >= built_len) begin
            r.status = bwg_pkg::STATUS_RANGE;
        end else begin
            r.coef = 24'(coef_mem[idx]);
        end
        awaited.push_back(r);
    endfunction

    function void check_result(logic [23:0] coef, logic [1:0] status);
        t_result r;
        if (awaited.size() == 0) begin
            $display("%0t: unexpected result beat, coefficient %h status %0d",
                     $realtime, coef, status);
            errors++;
            return;
        end
        r = awaited.pop_front();
        if (coef !== r.coef) begin
            $display("%0t: coefficient mismatch, expected %h actual %h",
                     $realtime, r.coef, coef);
            errors++;
        end
        if (status !== r.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $realtime, r.status, status);
            errors++;
        end
    endfunction

    function int pending();
        return awaited.size();
    endfunction
endclass

module tb_blackman_window_generator_core;
    import bwg_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [12:0] cfg_wdata;

    window_scoreboard sb = new();

    // When set, neither side inserts random gaps.
    bit quiet;
    // Request for one long hold-off on the result side.
    bit stall_req;
    int unsigned idle_cycles;

    blackman_window_generator_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    // Result side: random back-pressure, plus one long hold-off on request so
    // that the block fills up and has to refuse input beats.
    initial begin
        int unsigned gap;
        m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_req) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                stall_req = 0;
            end else begin
                gap = pick_gap();
                if (gap == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    repeat (gap - 1) @(posedge i_clk);
                end
            end
        end
    end

    // Every result beat is checked as it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    // The idle limit sits well above the run of a normalised build over the
    // longest window, during which no beat moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 1_000_000) begin
            $display("FAIL");
            $finish;
        end
    end

    // Offers one input beat; valid stays high into the next beat when there is
    // no gap, so it is never lowered and raised in the same step.
    task automatic send_beat(logic op, logic [11:0] idx);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, idx};
        s_tuser  <= op;
        do @(posedge i_clk); while (!s_tready);
        sb.note_input(op, idx);
    endtask

    // Stops offering beats and waits until every predicted result is in.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // Write enable is left high; the caller lowers it after the last write.
    task automatic write_reg(logic [1:0] addr, logic [12:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge i_clk);
        sb.set_cfg(addr, data);
    endtask

    task automatic set_window(logic [12:0] len, bit norm, bit exact);
        drain();
        write_reg(CFG_WINDOW_LENGTH, len);
        write_reg(CFG_NORMALIZE_SUM, {12'd0, norm});
        write_reg(CFG_EXACT_COEFFS, {12'd0, exact});
        cfg_we <= 1'b0;
    endtask

    initial begin
        int unsigned len;
        int unsigned count;
        int unsigned n;
        i_rst_n   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        quiet     = 0;
        stall_req = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reads before any build are refused.
        send_beat(OP_READ, 12'd0);
        send_beat(OP_READ, 12'hFFF);
        // Lengths below two are refused and leave nothing built.
        set_window(13'd0, 1'b0, 1'b0);
        send_beat(OP_BUILD, 12'hFFF);
        set_window(13'd1, 1'b1, 1'b1);
        send_beat(OP_BUILD, 12'd0);
        send_beat(OP_READ, 12'd0);
        // Two-point classic window sums to zero, so it stays unscaled.
        set_window(13'd2, 1'b1, 1'b0);
        send_beat(OP_BUILD, 12'd0);
        send_beat(OP_READ, 12'd0);
        send_beat(OP_READ, 12'd1);
        send_beat(OP_READ, 12'd2);
        set_window(13'd2, 1'b1, 1'b1);
        send_beat(OP_BUILD, 12'd0);
        send_beat(OP_READ, 12'd1);
        // Lengths above the store size are clipped to it.
        set_window(13'h1FFF, 1'b0, 1'b1);
        send_beat(OP_BUILD, 12'd0);
        send_beat(OP_READ, 12'hFFF);
        send_beat(OP_READ, 12'd2048);
        send_beat(OP_READ, 12'd0);
        // A register change without a build keeps the old length for reads.
        set_window(13'd3, 1'b1, 1'b0);
        send_beat(OP_READ, 12'd3000);
        // Longest window with normalisation.
        set_window(13'd4096, 1'b1, 1'b1);
        send_beat(OP_BUILD, 12'd5);
        send_beat(OP_READ, 12'd2048);
        send_beat(OP_READ, 12'd4095);
        send_beat(OP_READ, 12'd1);

        // Random phases: a fresh setting, a build, then mostly in-range reads.
        // The first phase always includes the long hold-off on the result side.
        count = 0;
        while (count < 2000) begin
            if ($urandom_range(0, 9) == 0) len = $urandom_range(0, 300);
            else len = $urandom_range(0, 40);
            set_window(13'(len), 1'($urandom), 1'($urandom));
            quiet = ($urandom_range(0, 4) == 0);
            send_beat(OP_BUILD, 12'($urandom));
            n = $urandom_range(40, 120);
            if (count == 0 || $urandom_range(0, 5) == 0) stall_req = 1;
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 49) == 0)
                    send_beat(OP_BUILD, 12'($urandom));
                else if ($urandom_range(0, 9) == 0 || len < 2)
                    send_beat(OP_READ, 12'($urandom));
                else
                    send_beat(OP_READ, 12'($urandom_range(0, len - 1)));
            end
            count += n + 1;
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
